[sv/ljpe_pkg.sv]
package ljpe_pkg;

  localparam int FRAC_BITS = 24;
  localparam int DIST_W    = 32;
  localparam int CFG_W     = 32;
  localparam int RES_W     = 48;
  localparam int W_W       = 56;
  localparam int DIV_STEP  = 4;

  localparam int A_STEPS    = DIST_W / DIV_STEP;
  localparam int B_STEPS    = W_W / DIV_STEP;
  localparam int C_STEPS    = RES_W / DIV_STEP;
  localparam int PIPE_DEPTH = A_STEPS + B_STEPS + C_STEPS + 11;

  localparam logic [CFG_W-1:0] CFG_RESET = 32'h0100_0000;
  localparam logic [63:0]      UCAP      = 64'h4000_0000_0000_0000;
  localparam logic [63:0]      Q12_LIMIT = 64'h4000_0000_0000_0000 / 64'd156;
  localparam logic [RES_W-1:0] OMAX      = 48'h7FFF_FFFF_FFFF;
  localparam logic [RES_W-1:0] OMIN      = 48'h8000_0000_0000;

  localparam logic [7:0] K6   = 8'd6;
  localparam logic [7:0] K12  = 8'd12;
  localparam logic [7:0] K42  = 8'd42;
  localparam logic [7:0] K156 = 8'd156;

  typedef enum logic {
    REG_WELL_DEPTH   = 1'b0,
    REG_LENGTH_SCALE = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [DIST_W-1:0] sep;
    logic              dz;
    logic              huge;
  } tag_t;

  typedef struct packed {
    tag_t              tag;
    logic [RES_W-1:0]  energy;
    logic              e_ovf;
    logic              f_neg;
    logic              s_neg;
    logic              b_big;
    logic              c_big;
    logic [DIST_W-1:0] c_rem;
    logic [23:0]       c_low;
  } mid_t;

  typedef struct packed {
    tag_t             tag;
    logic [RES_W-1:0] energy;
    logic             e_ovf;
    logic             f_neg;
    logic             s_neg;
    logic             c_big;
    logic             d_big;
  } late_t;

  function automatic logic [DIST_W+DIV_STEP-1:0] div_step(
    input logic [DIST_W-1:0]   rem,
    input logic [DIV_STEP-1:0] bits,
    input logic [DIST_W-1:0]   dv
  );
    logic [DIST_W:0]       t;
    logic [DIST_W-1:0]     r;
    logic [DIV_STEP-1:0]   q;
    r = rem;
    for (int i = DIV_STEP - 1; i >= 0; i--) begin
      t = {r, bits[i]};
      if (t >= {1'b0, dv}) begin
        t    = t - {1'b0, dv};
        q[i] = 1'b1;
      end else begin
        q[i] = 1'b0;
      end
      r = t[DIST_W-1:0];
    end
    return {r, q};
  endfunction

  function automatic logic [RES_W:0] pack_mag(
    input logic [79:0] mag,
    input logic        neg
  );
    logic [RES_W-1:0] m;
    logic             ovf;
    ovf = 1'b0;
    m   = mag[RES_W-1:0];
    if (neg) begin
      if (mag > 80'(OMIN)) begin
        ovf = 1'b1;
        m   = OMIN;
      end
      return {ovf, ~m + 48'd1};
    end
    if (mag > 80'(OMAX)) begin
      ovf = 1'b1;
      m   = OMAX;
    end
    return {ovf, m};
  endfunction

endpackage

[sv/lennard_jones_pair_eval.sv]
// Channel   Handshake                        Payload
// distance  distance_valid / distance_ready  distance
// result    result_valid / result_ready      energy, force_term, stiffness, overflow
// config    cfg_write (no wait)              cfg_index, cfg_data
//
// One item per cycle unless a held result stalls the pipeline. Three radix-16 divider
// chains run in series with the multiplier stages between them: q, then the first
// stiffness quotient, then the force and second stiffness quotients side by side.
// Reset clears the valid bits and sets both registers to 1.0.
// A held result stalls the pipeline only once its last stage is full; bubbles still move.
module lennard_jones_pair_eval (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [0:0]                    cfg_index,
  input  logic [ljpe_pkg::CFG_W-1:0]    cfg_data,
  input  logic                          distance_valid,
  output logic                          distance_ready,
  input  logic [ljpe_pkg::DIST_W-1:0]   distance,
  output logic                          result_valid,
  input  logic                          result_ready,
  output logic signed [ljpe_pkg::RES_W-1:0] energy,
  output logic signed [ljpe_pkg::RES_W-1:0] force_term,
  output logic signed [ljpe_pkg::RES_W-1:0] stiffness,
  output logic                          overflow
);
  import ljpe_pkg::*;

  logic [CFG_W-1:0]      well_depth;
  logic [CFG_W-1:0]      length_scale;
  logic                  adv;
  logic [PIPE_DEPTH-1:0] vld;
  logic                  vlast;

  // divider for q
  tag_t              a_tag [A_STEPS+1];
  logic [DIST_W-1:0] a_rem [A_STEPS+1];
  logic [DIST_W-1:0] a_sh  [A_STEPS+1];
  logic [DIST_W-1:0] a_quo [A_STEPS+1];

  // power and product stages
  tag_t        m_tag [1:9];
  logic [31:0] q1;
  logic [63:0] q2p;
  logic [63:0] q3p;
  logic [63:0] q6p;
  logic [39:0] q6;
  logic [59:0] pp_hi;
  logic [59:0] pp_lo;
  logic [39:0] q6_5;
  logic [55:0] q12;
  logic [63:0] mag_e, mag_f, mag_s;
  logic        neg_e, neg_f, neg_s;
  logic [65:0] pl_e, ph_e, pl_f, ph_f, pl_s, ph_s;
  logic        neg_e7, neg_f7, neg_s7;
  logic [97:0] prod_e, prod_f, prod_s;
  logic        neg_e8, neg_f8, neg_s8;

  logic [63:0] mag_e_next, mag_f_next, mag_s_next;
  logic        neg_e_next, neg_f_next, neg_s_next, huge_next;
  logic [63:0] t6, t12, t42, t156, e6, e12;
  logic [33:0] e4;

  // divider for the first stiffness quotient
  mid_t              b_mid [B_STEPS+1];
  logic [DIST_W-1:0] b_rem [B_STEPS+1];
  logic [W_W-1:0]    b_sh  [B_STEPS+1];
  logic [W_W-1:0]    b_quo [B_STEPS+1];

  logic [RES_W:0]    e_pk;
  logic [73:0]       zraw;
  logic [62:0]       z;
  mid_t              mid_next;

  // force and stiffness final dividers
  late_t             n_late [C_STEPS+1];
  logic [DIST_W-1:0] c_rem  [C_STEPS+1];
  logic [RES_W-1:0]  c_sh   [C_STEPS+1];
  logic [RES_W-1:0]  c_quo  [C_STEPS+1];
  logic [DIST_W-1:0] d_rem  [C_STEPS+1];
  logic [RES_W-1:0]  d_sh   [C_STEPS+1];
  logic [RES_W-1:0]  d_quo  [C_STEPS+1];

  logic [W_W-1:0]    w;
  late_t             late_next;
  late_t             lt;
  logic [RES_W:0]    f_pk, s_pk;
  logic [RES_W-1:0]  energy_next, force_next, stiff_next;
  logic              ovf_next;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      well_depth   <= CFG_RESET;
      length_scale <= CFG_RESET;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_WELL_DEPTH:   well_depth   <= cfg_data;
        REG_LENGTH_SCALE: length_scale <= cfg_data;
        default:          well_depth   <= well_depth;
      endcase
    end
  end

  // flow control
  assign vlast          = vld[PIPE_DEPTH-1];
  assign adv            = !vlast || !result_valid || result_ready;
  assign distance_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[PIPE_DEPTH-2:0], distance_valid};
    end
  end

  // q = length_scale / distance
  always_ff @(posedge clk) begin
    if (adv) begin
      a_tag[0] <= '{sep: distance, dz: (distance == '0),
                    huge: ((length_scale >> (DIST_W - FRAC_BITS)) >= distance)};
      a_rem[0] <= length_scale >> (DIST_W - FRAC_BITS);
      a_sh[0]  <= length_scale << FRAC_BITS;
      a_quo[0] <= '0;
    end
  end

  for (genvar k = 1; k <= A_STEPS; k++) begin : g_a
    logic [DIST_W+DIV_STEP-1:0] st;
    assign st = div_step(a_rem[k-1], a_sh[k-1][DIST_W-1 -: DIV_STEP], a_tag[k-1].sep);
    always_ff @(posedge clk) begin
      if (adv) begin
        a_tag[k] <= a_tag[k-1];
        a_rem[k] <= st[DIST_W+DIV_STEP-1:DIV_STEP];
        a_sh[k]  <= a_sh[k-1] << DIV_STEP;
        a_quo[k] <= {a_quo[k-1][DIST_W-DIV_STEP-1:0], st[DIV_STEP-1:0]};
      end
    end
  end

  // powers, differences and scaling
  always_comb begin
    e6   = 64'(q6_5);
    e12  = 64'(q12);
    t6   = e6 * 64'(K6);
    t12  = e12 * 64'(K12);
    t42  = e6 * 64'(K42);
    t156 = e12 * 64'(K156);
    huge_next  = m_tag[5].huge || (e12 > Q12_LIMIT);
    neg_e_next = e6 > e12;
    mag_e_next = neg_e_next ? e6 - e12 : e12 - e6;
    neg_f_next = t12 > t6;
    mag_f_next = neg_f_next ? t12 - t6 : t6 - t12;
    neg_s_next = t42 > t156;
    mag_s_next = neg_s_next ? t42 - t156 : t156 - t42;
    e4 = {well_depth, 2'b00};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tag[1] <= a_tag[A_STEPS];
      q1       <= a_quo[A_STEPS];
      q2p      <= 64'(a_quo[A_STEPS]) * 64'(a_quo[A_STEPS]);

      m_tag[2] <= '{sep: m_tag[1].sep, dz: m_tag[1].dz,
                    huge: m_tag[1].huge || (|q2p[63:56])};
      q3p      <= 64'(q2p[55:24]) * 64'(q1);

      m_tag[3] <= '{sep: m_tag[2].sep, dz: m_tag[2].dz,
                    huge: m_tag[2].huge || (|q3p[63:56])};
      q6p      <= 64'(q3p[55:24]) * 64'(q3p[55:24]);

      m_tag[4] <= m_tag[3];
      q6       <= q6p[63:24];
      pp_hi    <= 60'(q6p[63:44]) * 60'(q6p[63:24]);
      pp_lo    <= 60'(q6p[43:24]) * 60'(q6p[63:24]);

      m_tag[5] <= m_tag[4];
      q6_5     <= q6;
      q12      <= 56'(({pp_hi, 20'b0} + 80'(pp_lo)) >> FRAC_BITS);

      m_tag[6] <= '{sep: m_tag[5].sep, dz: m_tag[5].dz, huge: huge_next};
      mag_e    <= mag_e_next;
      mag_f    <= mag_f_next;
      mag_s    <= mag_s_next;
      neg_e    <= neg_e_next;
      neg_f    <= neg_f_next;
      neg_s    <= neg_s_next;

      m_tag[7] <= m_tag[6];
      pl_e     <= 66'(mag_e[31:0]) * 66'(e4);
      ph_e     <= 66'(mag_e[63:32]) * 66'(e4);
      pl_f     <= 66'(mag_f[31:0]) * 66'(e4);
      ph_f     <= 66'(mag_f[63:32]) * 66'(e4);
      pl_s     <= 66'(mag_s[31:0]) * 66'(e4);
      ph_s     <= 66'(mag_s[63:32]) * 66'(e4);
      neg_e7   <= neg_e;
      neg_f7   <= neg_f;
      neg_s7   <= neg_s;

      m_tag[8] <= m_tag[7];
      prod_e   <= {ph_e, 32'b0} + 98'(pl_e);
      prod_f   <= {ph_f, 32'b0} + 98'(pl_f);
      prod_s   <= {ph_s, 32'b0} + 98'(pl_s);
      neg_e8   <= neg_e7;
      neg_f8   <= neg_f7;
      neg_s8   <= neg_s7;
    end
  end

  // energy result, divider setup
  always_comb begin
    e_pk = pack_mag({6'b0, prod_e[97:24]}, neg_e8);
    zraw = prod_s[97:24];
    z    = (zraw > 74'(UCAP)) ? UCAP[62:0] : zraw[62:0];
    mid_next.tag    = m_tag[8];
    mid_next.energy = e_pk[RES_W-1:0];
    mid_next.e_ovf  = e_pk[RES_W];
    mid_next.f_neg  = neg_f8;
    mid_next.s_neg  = neg_s8;
    mid_next.b_big  = {1'b0, z[62:32]} >= m_tag[8].sep;
    mid_next.c_big  = prod_f[97:48] >= 50'(m_tag[8].sep);
    mid_next.c_rem  = prod_f[79:48];
    mid_next.c_low  = prod_f[47:24];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_mid[0] <= mid_next;
      b_rem[0] <= {1'b0, z[62:32]};
      b_sh[0]  <= {z[31:0], 24'b0};
      b_quo[0] <= '0;
    end
  end

  for (genvar k = 1; k <= B_STEPS; k++) begin : g_b
    logic [DIST_W+DIV_STEP-1:0] st;
    assign st = div_step(b_rem[k-1], b_sh[k-1][W_W-1 -: DIV_STEP], b_mid[k-1].tag.sep);
    always_ff @(posedge clk) begin
      if (adv) begin
        b_mid[k] <= b_mid[k-1];
        b_rem[k] <= st[DIST_W+DIV_STEP-1:DIV_STEP];
        b_sh[k]  <= b_sh[k-1] << DIV_STEP;
        b_quo[k] <= {b_quo[k-1][W_W-DIV_STEP-1:0], st[DIV_STEP-1:0]};
      end
    end
  end

  // second stiffness quotient and force quotient
  always_comb begin
    w = b_quo[B_STEPS];
    late_next.tag    = b_mid[B_STEPS].tag;
    late_next.energy = b_mid[B_STEPS].energy;
    late_next.e_ovf  = b_mid[B_STEPS].e_ovf;
    late_next.f_neg  = b_mid[B_STEPS].f_neg;
    late_next.s_neg  = b_mid[B_STEPS].s_neg;
    late_next.c_big  = b_mid[B_STEPS].c_big;
    late_next.d_big  = b_mid[B_STEPS].b_big || (w[55:24] >= b_mid[B_STEPS].tag.sep);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      n_late[0] <= late_next;
      c_rem[0]  <= b_mid[B_STEPS].c_rem;
      c_sh[0]   <= {b_mid[B_STEPS].c_low, 24'b0};
      c_quo[0]  <= '0;
      d_rem[0]  <= w[55:24];
      d_sh[0]   <= {w[23:0], 24'b0};
      d_quo[0]  <= '0;
    end
  end

  for (genvar k = 1; k <= C_STEPS; k++) begin : g_c
    logic [DIST_W+DIV_STEP-1:0] cs;
    logic [DIST_W+DIV_STEP-1:0] ds;
    assign cs = div_step(c_rem[k-1], c_sh[k-1][RES_W-1 -: DIV_STEP], n_late[k-1].tag.sep);
    assign ds = div_step(d_rem[k-1], d_sh[k-1][RES_W-1 -: DIV_STEP], n_late[k-1].tag.sep);
    always_ff @(posedge clk) begin
      if (adv) begin
        n_late[k] <= n_late[k-1];
        c_rem[k]  <= cs[DIST_W+DIV_STEP-1:DIV_STEP];
        c_sh[k]   <= c_sh[k-1] << DIV_STEP;
        c_quo[k]  <= {c_quo[k-1][RES_W-DIV_STEP-1:0], cs[DIV_STEP-1:0]};
        d_rem[k]  <= ds[DIST_W+DIV_STEP-1:DIV_STEP];
        d_sh[k]   <= d_sh[k-1] << DIV_STEP;
        d_quo[k]  <= {d_quo[k-1][RES_W-DIV_STEP-1:0], ds[DIV_STEP-1:0]};
      end
    end
  end

  // final selection
  assign lt = n_late[C_STEPS];

  always_comb begin
    f_pk = pack_mag(lt.c_big ? {80{1'b1}} : {32'b0, c_quo[C_STEPS]}, lt.f_neg);
    s_pk = pack_mag(lt.d_big ? {80{1'b1}} : {32'b0, d_quo[C_STEPS]}, lt.s_neg);
    if (lt.tag.dz || (well_depth != '0 && lt.tag.huge)) begin
      energy_next = OMAX;
      force_next  = OMIN;
      stiff_next  = OMAX;
      ovf_next    = 1'b1;
    end else if (well_depth == '0) begin
      energy_next = '0;
      force_next  = '0;
      stiff_next  = '0;
      ovf_next    = 1'b0;
    end else begin
      energy_next = lt.energy;
      force_next  = f_pk[RES_W-1:0];
      stiff_next  = s_pk[RES_W-1:0];
      ovf_next    = lt.e_ovf || f_pk[RES_W] || s_pk[RES_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= vlast || (result_valid && !result_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (adv && vlast) begin
      energy     <= $signed(energy_next);
      force_term <= $signed(force_next);
      stiffness  <= $signed(stiff_next);
      overflow   <= ovf_next;
    end
  end

endmodule

[sv/ljpe_checker.sv]
module ljpe_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              distance_ready,
  input logic                              result_valid,
  input logic                              result_ready,
  input logic signed [ljpe_pkg::RES_W-1:0] energy,
  input logic signed [ljpe_pkg::RES_W-1:0] force_term,
  input logic signed [ljpe_pkg::RES_W-1:0] stiffness,
  input logic                              overflow
);
  import ljpe_pkg::*;

  a_reset_clears: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(energy) &&
    $stable(force_term) && $stable(stiffness) && $stable(overflow))
    else $error("stalled result changed");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> distance_ready)
    else $error("input stalled with empty output");

  a_zero_no_ovf: assert property (@(posedge clk) disable iff (rst)
    result_valid && energy == '0 && force_term == '0 && stiffness == '0 |-> !overflow)
    else $error("overflow on an all-zero result");

endmodule

bind lennard_jones_pair_eval ljpe_checker u_ljpe_checker (.*);
